[rtl/b58enc_pkg.sv]
// ----------------------------------------------------------------------------
// b58enc_pkg
// Types, constants and the alphabet lookup shared by the base-58 encoder.
// ----------------------------------------------------------------------------
package b58enc_pkg;

  localparam int unsigned Radix    = 58;
  localparam int unsigned MaxOut   = 45;
  localparam int unsigned TotW     = 8;
  localparam int unsigned VW       = 14;
  localparam int unsigned DivMul   = 1130;
  localparam int unsigned DivShift = 16;
  localparam int unsigned ProdW    = 25;

  localparam logic [6:0] CapReset = 7'd64;
  localparam logic [6:0] CharOne  = 7'h31;

  typedef enum logic [1:0] {
    StatusOk    = 2'd0,
    StatusSmall = 2'd1,
    StatusLong  = 2'd2
  } status_e;

  typedef enum logic [6:0] {
    S_CLEAR  = 7'b0000001,
    S_IDLE   = 7'b0000010,
    S_FOLD   = 7'b0000100,
    S_FINISH = 7'b0001000,
    S_ZEROS  = 7'b0010000,
    S_DRD    = 7'b0100000,
    S_DLD    = 7'b1000000
  } state_e;

  typedef struct packed {
    logic [6:0] char_code;
    logic       is_last;
    status_e    status;
    logic [6:0] needed_size;
  } result_t;

  function automatic logic [6:0] alpha58(input logic [5:0] d);
    logic [6:0] dx;
    logic [6:0] ch;
    dx = {1'b0, d};
    if (dx < 7'd9) begin
      ch = 7'h31 + dx;
    end else if (dx < 7'd17) begin
      ch = 7'h41 + (dx - 7'd9);
    end else if (dx < 7'd22) begin
      ch = 7'h4A + (dx - 7'd17);
    end else if (dx < 7'd33) begin
      ch = 7'h50 + (dx - 7'd22);
    end else if (dx < 7'd44) begin
      ch = 7'h61 + (dx - 7'd33);
    end else begin
      ch = 7'h6D + (dx - 7'd44);
    end
    return ch;
  endfunction

endpackage

[rtl/b58enc_ram.sv]
// ----------------------------------------------------------------------------
// b58enc_ram
// Generic single-write, single-read synchronous RAM with registered read data.
// ----------------------------------------------------------------------------
module b58enc_ram #(
  parameter int unsigned WIDTH = 6,
  parameter int unsigned DEPTH = 45
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[rtl/base58_encoder.sv]
// ----------------------------------------------------------------------------
// base58_encoder
// Byte-serial base-58 encoder (Bitcoin alphabet) with a RAM digit store.
// ----------------------------------------------------------------------------
// Channel   Dir  Handshake               Payload
// s_axis    in   s_axis_tvalid/tready    tdata[7:0] data_byte, tlast last_byte
// m_axis    out  m_axis_tvalid/tready    tdata char_code/needed_size, tlast, tuser
// cfg       in   cfg_valid_i/cfg_ready_o cfg_data_i out_capacity
//
// A zero prefix byte is only counted; any other byte is folded into the stored
// digits one digit per cycle through the single read port of the digit RAM.
// Output: one '1' per cycle unless stalled, then per digit a RAM read, then a load.
// After reset and after every message a clearing pass zeroes the RAM; no item
// is accepted meanwhile.
// A result waits in the output register while the next message is taken in.
// ----------------------------------------------------------------------------
module base58_encoder
  import b58enc_pkg::*;
#(
  parameter int unsigned MAX_BYTES = 32,
  parameter int unsigned DIGITS    = 45
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
  input  logic        s_axis_tlast,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,   // [6:0] char_code, [13:7] needed_size, [15:14] 0
  output logic        m_axis_tlast,
  output logic [1:0]  m_axis_tuser,   // [1:0] status
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [6:0]  cfg_data_i
);

  localparam int unsigned IdxW   = $clog2(DIGITS);
  localparam int unsigned FirstW = $clog2(DIGITS + 1);
  localparam int unsigned ZcW    = $clog2(MAX_BYTES + 1);
  localparam int unsigned BtW    = $clog2(MAX_BYTES + 2);

  state_e            state_q, state_d;
  logic [6:0]        cap_q;
  logic [ZcW-1:0]    zpc_q, zpc_d;
  logic              seen_q, seen_d;
  logic [BtW-1:0]    bt_q, bt_d;
  logic              ovf_q, ovf_d;
  logic              last_q, last_d;
  logic [FirstW-1:0] first_q, first_d;
  logic [7:0]        carry_q, carry_d;
  logic [IdxW-1:0]   idx_q, idx_d;
  logic [ZcW-1:0]    cnt_q, cnt_d;
  logic              out_valid_q, out_valid_d;
  result_t           out_q, out_d;

  logic              ram_we;
  logic [IdxW-1:0]   ram_waddr;
  logic [5:0]        ram_wdata;
  logic              ram_re;
  logic [IdxW-1:0]   ram_raddr;
  logic [5:0]        ram_rdata;

  logic [VW-1:0]     fold_v;
  logic [ProdW-1:0]  fold_prod;
  logic [7:0]        fold_q;
  logic [5:0]        fold_r;
  logic [FirstW-1:0] sig;
  logic [TotW-1:0]   total;
  logic              out_free;
  logic              in_fire;
  logic              no_digits;

  b58enc_ram #(
    .WIDTH(6),
    .DEPTH(DIGITS)
  ) u_store (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .re_i   (ram_re),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  assign fold_v    = {ram_rdata, 8'h00} + VW'(carry_q);
  assign fold_prod = ProdW'(fold_v) * ProdW'(DivMul);
  assign fold_q    = fold_prod[DivShift+7:DivShift];
  assign fold_r    = 6'(fold_v - VW'(fold_q) * VW'(Radix));

  assign sig       = FirstW'(DIGITS) - first_q;
  assign total     = TotW'(zpc_q) + TotW'(sig);
  assign no_digits = (first_q == FirstW'(DIGITS));

  assign out_free      = !out_valid_q || m_axis_tready;
  assign s_axis_tready = (state_q == S_IDLE);
  assign in_fire       = s_axis_tvalid && s_axis_tready;
  assign cfg_ready_o   = 1'b1;

  always_comb begin
    state_d     = state_q;
    zpc_d       = zpc_q;
    seen_d      = seen_q;
    bt_d        = bt_q;
    ovf_d       = ovf_q;
    last_d      = last_q;
    first_d     = first_q;
    carry_d     = carry_q;
    idx_d       = idx_q;
    cnt_d       = cnt_q;
    out_valid_d = out_valid_q && !m_axis_tready;
    out_d       = out_q;
    ram_we      = 1'b0;
    ram_waddr   = idx_q;
    ram_wdata   = '0;
    ram_re      = 1'b0;
    ram_raddr   = IdxW'(DIGITS - 1);

    unique case (state_q)
      S_CLEAR: begin
        ram_we = 1'b1;
        idx_d  = idx_q + IdxW'(1);
        if (idx_q == IdxW'(DIGITS - 1)) begin
          idx_d   = '0;
          zpc_d   = '0;
          seen_d  = 1'b0;
          bt_d    = '0;
          ovf_d   = 1'b0;
          first_d = FirstW'(DIGITS);
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        ram_re = 1'b1;
        if (in_fire) begin
          last_d  = s_axis_tlast;
          state_d = s_axis_tlast ? S_FINISH : S_IDLE;
          if (bt_q < BtW'(MAX_BYTES)) begin
            bt_d = bt_q + BtW'(1);
            if (!seen_q && s_axis_tdata == 8'h00) begin
              zpc_d = zpc_q + ZcW'(1);
            end else begin
              seen_d  = 1'b1;
              carry_d = s_axis_tdata;
              idx_d   = IdxW'(DIGITS - 1);
              first_d = FirstW'(DIGITS);
              state_d = S_FOLD;
            end
          end else begin
            bt_d = BtW'(MAX_BYTES + 1);
          end
        end
      end
      S_FOLD: begin
        ram_we    = 1'b1;
        ram_wdata = fold_r;
        ram_re    = (idx_q != '0);
        ram_raddr = idx_q - IdxW'(1);
        carry_d   = fold_q;
        if (fold_r != 6'd0) begin
          first_d = FirstW'(idx_q);
        end
        idx_d = idx_q - IdxW'(1);
        if (idx_q == '0) begin
          idx_d = '0;
          if (fold_q != 8'h00) begin
            ovf_d = 1'b1;
          end
          state_d = last_q ? S_FINISH : S_IDLE;
        end
      end
      S_FINISH: begin
        if (out_free) begin
          if (bt_q > BtW'(MAX_BYTES) || ovf_q || total > TotW'(MaxOut)) begin
            out_valid_d = 1'b1;
            out_d       = '{char_code: '0, is_last: 1'b1, status: StatusLong,
                            needed_size: '0};
            idx_d       = '0;
            state_d     = S_CLEAR;
          end else if ({1'b0, cap_q} <= total) begin
            out_valid_d = 1'b1;
            out_d       = '{char_code: '0, is_last: 1'b1, status: StatusSmall,
                            needed_size: 7'(total + TotW'(1))};
            idx_d       = '0;
            state_d     = S_CLEAR;
          end else if (zpc_q != '0) begin
            cnt_d   = '0;
            state_d = S_ZEROS;
          end else begin
            idx_d   = IdxW'(first_q);
            state_d = S_DRD;
          end
        end
      end
      S_ZEROS: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_d       = '{char_code: CharOne,
                          is_last: (cnt_q == zpc_q - ZcW'(1)) && no_digits,
                          status: StatusOk, needed_size: '0};
          cnt_d       = cnt_q + ZcW'(1);
          if (cnt_q == zpc_q - ZcW'(1)) begin
            if (no_digits) begin
              idx_d   = '0;
              state_d = S_CLEAR;
            end else begin
              idx_d   = IdxW'(first_q);
              state_d = S_DRD;
            end
          end
        end
      end
      S_DRD: begin
        ram_re    = 1'b1;
        ram_raddr = idx_q;
        state_d   = S_DLD;
      end
      S_DLD: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_d       = '{char_code: alpha58(ram_rdata),
                          is_last: (idx_q == IdxW'(DIGITS - 1)),
                          status: StatusOk, needed_size: '0};
          if (idx_q == IdxW'(DIGITS - 1)) begin
            idx_d   = '0;
            state_d = S_CLEAR;
          end else begin
            idx_d   = idx_q + IdxW'(1);
            state_d = S_DRD;
          end
        end
      end
      default: begin
        idx_d   = '0;
        state_d = S_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      cap_q       <= CapReset;
      zpc_q       <= '0;
      seen_q      <= 1'b0;
      bt_q        <= '0;
      ovf_q       <= 1'b0;
      last_q      <= 1'b0;
      first_q     <= FirstW'(DIGITS);
      idx_q       <= '0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      zpc_q       <= zpc_d;
      seen_q      <= seen_d;
      bt_q        <= bt_d;
      ovf_q       <= ovf_d;
      last_q      <= last_d;
      first_q     <= first_d;
      idx_q       <= idx_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
      if (cfg_valid_i && cfg_ready_o) begin
        cap_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    carry_q <= carry_d;
    out_q   <= out_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {2'b00, out_q.needed_size, out_q.char_code};
  assign m_axis_tlast  = out_q.is_last;
  assign m_axis_tuser  = out_q.status;

endmodule
